// File: rtl/swz_pkg.sv
// ----------------------------------------------------------------------------
// swz_pkg: shared types and constants of the sliding-window z-score detector
// Holds the sequencer states, divider request type, field widths and limits.
// ----------------------------------------------------------------------------
`default_nettype none
package swz_pkg;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned MinFill = 10;
  localparam logic [ThrW-1:0] ThrReset = 16'd1280;

  typedef enum logic [3:0] {
    StIdle,
    StSumRd,
    StSumAcc,
    StMeanDiv,
    StVarRd,
    StVarAcc,
    StVarDiv,
    StSqrt,
    StZDiv,
    StFinish,
    StOut
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [127:0] dividend;
    logic [63:0]  divisor;
    logic [7:0]   steps;
  } div_req_t;
endpackage
`default_nettype wire

// File: rtl/swz_div.sv
// ----------------------------------------------------------------------------
// swz_div: shared restoring divider
// Takes one quotient bit per cycle; the dividend is aligned so that the
// requested number of steps covers its significant bits.
// ----------------------------------------------------------------------------
`default_nettype none
module swz_div
  import swz_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire div_req_t     req_i,
  output logic              busy_o,
  output logic [127:0]      quot_o
);
  logic [127:0] num_q, num_d;
  logic [63:0]  rem_q, rem_d, div_q;
  logic [7:0]   cnt_q, cnt_d;
  logic [64:0]  trial;

  // The dividend is left-aligned by the caller: only its top "steps" bits
  // are shifted through the remainder.
  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    trial = {rem_q, num_q[127]} - {1'b0, div_q};
    if (req_i.start) begin
      num_d = req_i.dividend;
      rem_d = '0;
      cnt_d = req_i.steps;
    end else if (cnt_q != 8'd0) begin
      if (!trial[64]) rem_d = trial[63:0];
      else            rem_d = {rem_q[62:0], num_q[127]};
      num_d = {num_q[126:0], ~trial[64]};
      cnt_d = cnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (req_i.start) div_q <= req_i.divisor;
  end

  assign busy_o = (cnt_q != 8'd0);
  assign quot_o = num_q;
endmodule
`default_nettype wire

// File: rtl/sliding_window_zscore_detector.sv
// ----------------------------------------------------------------------------
// sliding_window_zscore_detector: windowed z-score anomaly detector
// Keeps the last WINDOW samples, recomputes mean and population sd per
// sample and alarms when its z-score reaches threshold from MinFill entries on.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   s_axis    in         error_sample (32 bit signed Q16.16)
//   m_axis    out        z_value, window_mean, window_sd, max_z_seen,
//                        update_count, alarm_count in tdata; alarm, in_crisis
//                        in tuser
//   cfg       in         sigma_threshold (16 bit unsigned Q8.8)
//
// With N valid window entries, the block handles each input beat with two passes
// over the N entries (one registered read port), the 64-step mean divide, the
// 128-step variance divide, the 32-step square root, the 80-step z divide
// (skipped when the sd is zero), the flag update and the output beat, and then
// returns to idle, where the next beat is accepted.
// No clearing pass follows reset: only written entries are read.
// s_axis_tready is low while a beat is in work or its result waits on m_axis.
// ----------------------------------------------------------------------------
`default_nettype none
module sliding_window_zscore_detector
  import swz_pkg::*;
#(
  parameter int unsigned WINDOW = 128
)(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // [31:0] error_sample
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] z_value, [63:32] window_mean, [95:64] window_sd,
  // [127:96] max_z_seen, [159:128] update_count, [191:160] alarm_count
  output logic [191:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser,   // [0] alarm, [1] in_crisis
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [15:0]  cfg_data_i
);
  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);

  state_e state_q, state_d;

  // Sample memory: one write port, one registered read port.
  logic [DataW-1:0] mem [WINDOW];
  logic [DataW-1:0] rd_q;
  logic             we;
  logic [AW-1:0]    rd_addr;

  logic [AW-1:0]    slot_q, slot_d, idx_q, idx_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [ThrW-1:0]  thr_q;
  logic [DataW-1:0] x_q, x_d;
  logic [63:0]      sum_q, sum_d;      // signed window sum
  logic [127:0]     sq_q, sq_d;        // sum of squared deviations
  logic [31:0]      mean_q, mean_d, sd_q, sd_d, z_q, z_d;
  logic [63:0]      var_q, var_d;
  logic [63:0]      srem_q, srem_d;    // square root remainder
  logic [5:0]       scnt_q, scnt_d;
  logic [31:0]      peak_q, peak_d, upd_q, upd_d, alm_q, alm_d;
  logic             crisis_q, crisis_d, alarm_q, alarm_d;
  logic             neg_q, neg_d;

  div_req_t     dreq;
  logic         dbusy;
  logic [127:0] dquot;

  swz_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .busy_o (dbusy),
    .quot_o (dquot)
  );

  logic [63:0]  sq_mult, d64, zq;
  logic [31:0]  dmag;
  logic [65:0]  strial;
  logic [33:0]  thr_full, thr_half;

  assign we      = (state_q == StIdle) && s_axis_tvalid && s_axis_tready;
  assign rd_addr = idx_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[slot_q] <= s_axis_tdata;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    idx_d    = idx_q;
    fill_d   = fill_q;
    x_d      = x_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    mean_d   = mean_q;
    var_d    = var_q;
    sd_d     = sd_q;
    srem_d   = srem_q;
    scnt_d   = scnt_q;
    z_d      = z_q;
    neg_d    = neg_q;
    peak_d   = peak_q;
    upd_d    = upd_q;
    alm_d    = alm_q;
    crisis_d = crisis_q;
    alarm_d  = alarm_q;
    dreq     = '0;
    d64      = {{32{rd_q[31]}}, rd_q} - {{32{mean_q[31]}}, mean_q};
    dmag     = d64[63] ? 32'(~d64 + 64'd1) : d64[31:0];
    sq_mult  = 64'(dmag) * 64'(dmag);
    strial   = {srem_q, var_q[63:62]} - {32'd0, sd_q, 2'b01};
    zq       = dquot[63:0];
    thr_full = {10'd0, thr_q, 8'd0};
    thr_half = {11'd0, thr_q, 7'd0};
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          x_d    = s_axis_tdata;
          slot_d = (32'(slot_q) + 32'd1 >= WINDOW) ? '0 : AW'(32'(slot_q) + 32'd1);
          if (32'(fill_q) < WINDOW) fill_d = fill_q + CW'(1);
          idx_d   = '0;
          sum_d   = '0;
          sq_d    = '0;
          state_d = StSumRd;
        end
      end
      StSumRd:  state_d = StSumAcc;
      StSumAcc: begin
        sum_d = sum_q + {{32{rd_q[31]}}, rd_q};
        if (32'(idx_q) + 32'd1 >= 32'(fill_q)) begin
          idx_d   = '0;
          state_d = StMeanDiv;
          dreq.start    = 1'b1;
          dreq.dividend = {sum_d[63] ? (~sum_d + 64'd1) : sum_d, 64'd0};
          dreq.divisor  = 64'(fill_q);
          dreq.steps    = 8'd64;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = StSumRd;
        end
      end
      StMeanDiv: begin
        if (!dbusy) begin
          // Truncation toward zero; the mean fits in 32 bits.
          mean_d  = sum_q[63] ? 32'(~zq + 64'd1) : zq[31:0];
          state_d = StVarRd;
        end
      end
      StVarRd:  state_d = StVarAcc;
      StVarAcc: begin
        sq_d = sq_q + 128'(sq_mult);
        if (32'(idx_q) + 32'd1 >= 32'(fill_q)) begin
          state_d = StVarDiv;
          dreq.start    = 1'b1;
          dreq.dividend = sq_d;
          dreq.divisor  = 64'(fill_q);
          dreq.steps    = 8'd128;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = StVarRd;
        end
      end
      StVarDiv: begin
        if (!dbusy) begin
          var_d   = zq;
          sd_d    = '0;
          srem_d  = '0;
          scnt_d  = 6'd32;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        // Digit-by-digit square root, two radicand bits per step.
        if (scnt_q == 6'd0) begin
          d64 = {{32{x_q[31]}}, x_q} - {{32{mean_q[31]}}, mean_q};
          neg_d = d64[63];
          if (sd_q == 32'd0) begin
            z_d     = '0;
            state_d = StFinish;
          end else begin
            // The top 80 bits hold the deviation magnitude shifted up by 16.
            dreq.start    = 1'b1;
            dreq.dividend = {d64[63] ? (~d64 + 64'd1) : d64, 64'd0};
            dreq.divisor  = 64'(sd_q);
            dreq.steps    = 8'd80;
            state_d       = StZDiv;
          end
        end else begin
          if (!strial[65]) begin
            srem_d = strial[63:0];
            sd_d   = {sd_q[30:0], 1'b1};
          end else begin
            srem_d = {srem_q[61:0], var_q[63:62]};
            sd_d   = {sd_q[30:0], 1'b0};
          end
          var_d  = {var_q[61:0], 2'b00};
          scnt_d = scnt_q - 6'd1;
        end
      end
      StZDiv: begin
        if (!dbusy) begin
          // 80 steps leave the quotient in the low 80 bits.
          if (neg_q) begin
            z_d = (dquot[79:32] != '0 || zq[31:0] > 32'h8000_0000) ? 32'h8000_0000
                                                                   : (~zq[31:0] + 32'd1);
          end else begin
            z_d = (dquot[79:31] != '0) ? 32'h7FFF_FFFF : zq[31:0];
          end
          state_d = StFinish;
        end
      end
      StFinish: begin
        if ($signed(z_q) > $signed(peak_q)) peak_d = z_q;
        if (upd_q != '1) upd_d = upd_q + 32'd1;
        alarm_d = (32'(fill_q) >= MinFill) &&
                  ($signed({{2{z_q[31]}}, z_q}) >= $signed(thr_full));
        if (alarm_d) begin
          crisis_d = 1'b1;
          if (alm_q != '1) alm_d = alm_q + 32'd1;
        end else if (crisis_q &&
                     ($signed({{2{z_q[31]}}, z_q}) < $signed(thr_half))) begin
          crisis_d = 1'b0;
        end
        state_d = StOut;
      end
      StOut: begin
        if (m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      slot_q   <= '0;
      fill_q   <= '0;
      crisis_q <= 1'b0;
      peak_q   <= '0;
      upd_q    <= '0;
      alm_q    <= '0;
      thr_q    <= ThrReset;
      idx_q    <= '0;
      scnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      fill_q   <= fill_d;
      crisis_q <= crisis_d;
      peak_q   <= peak_d;
      upd_q    <= upd_d;
      alm_q    <= alm_d;
      idx_q    <= idx_d;
      scnt_q   <= scnt_d;
      if (cfg_valid_i) thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    sum_q   <= sum_d;
    sq_q    <= sq_d;
    mean_q  <= mean_d;
    var_q   <= var_d;
    sd_q    <= sd_d;
    srem_q  <= srem_d;
    z_q     <= z_d;
    neg_q   <= neg_d;
    alarm_q <= alarm_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {alm_q, upd_q, peak_q, sd_q, mean_q, z_q};
  assign m_axis_tuser  = {crisis_q, alarm_q};
endmodule
`default_nettype wire
